// File: hdl/prbs_pkg.sv
// Shared types and constants for the priority request buffer select block.
// No dependencies; every other file of the block refers to this package.
package prbs_pkg;

  localparam int unsigned SlotsDefault     = 8;
  localparam int unsigned MaxSourceDefault = 15;

  localparam int unsigned SourceW   = 4;
  localparam int unsigned SequenceW = 16;
  localparam int unsigned StampW    = 32;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned SiuW      = 4;

  localparam logic [SiuW-1:0] SiuReset = 4'd8;

  typedef enum logic {
    CmdWrite  = 1'b0,
    CmdSelect = 1'b1
  } cmd_e;

  // One stored request.
  typedef struct packed {
    logic [SourceW-1:0]   source;
    logic [SequenceW-1:0] sequence_num;
    logic [StampW-1:0]    stamp;
  } slot_entry_t;

endpackage

// File: hdl/prbs_slot_store.sv
// Request slot storage: entry memory plus per-slot occupancy marks.
// Depends on prbs_pkg for the entry type.
module prbs_slot_store #(
  parameter int unsigned SLOTS = prbs_pkg::SlotsDefault,
  parameter int unsigned IW    = $clog2(SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IW-1:0]         wr_idx_i,
  input  prbs_pkg::slot_entry_t wr_entry_i,
  input  logic                  clr_en_i,
  input  logic [IW-1:0]         clr_idx_i,
  input  logic                  rd_en_i,
  input  logic [IW-1:0]         rd_idx_i,
  output prbs_pkg::slot_entry_t rd_entry_o,
  output logic                  rd_occ_o,
  output logic [IW-1:0]         rd_idx_o
);

  prbs_pkg::slot_entry_t mem [SLOTS];
  logic [SLOTS-1:0]      occ_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_o <= mem[rd_idx_i];
      rd_idx_o   <= rd_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      rd_occ_o <= 1'b0;
    end else begin
      if (wr_en_i) begin
        occ_q[wr_idx_i] <= (wr_entry_i.source != '0);
      end else if (clr_en_i) begin
        occ_q[clr_idx_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_occ_o <= occ_q[rd_idx_i];
      end
    end
  end

endmodule

// File: hdl/prbs_scan_unit.sv
// Shared compare unit: keeps the best request seen so far during a scan.
// Depends on prbs_pkg for the entry type.
module prbs_scan_unit #(
  parameter int unsigned IW = prbs_pkg::SlotW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  init_i,
  input  logic                  cand_valid_i,
  input  logic                  cand_occ_i,
  input  prbs_pkg::slot_entry_t cand_entry_i,
  input  logic [IW-1:0]         cand_idx_i,
  output logic                  have_o,
  output prbs_pkg::slot_entry_t best_entry_o,
  output logic [IW-1:0]         best_idx_o
);

  logic better;

  // Strict compares keep the lower slot index on a full tie.
  always_comb begin
    better = cand_valid_i && cand_occ_i &&
             (!have_o ||
              (cand_entry_i.source < best_entry_o.source) ||
              ((cand_entry_i.source == best_entry_o.source) &&
               (cand_entry_i.sequence_num < best_entry_o.sequence_num)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_o <= 1'b0;
    end else if (init_i) begin
      have_o <= 1'b0;
    end else if (better) begin
      have_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      best_entry_o <= '0;
      best_idx_o   <= '0;
    end else if (better) begin
      best_entry_o <= cand_entry_i;
      best_idx_o   <= cand_idx_i;
    end
  end

endmodule

// File: hdl/priority_request_buffer_select.sv
// Top level of the priority request buffer select block.
// Depends on prbs_pkg, prbs_slot_store and prbs_scan_unit.
//
// Usage: drive start with a request; it is taken when busy is low. With n
// as min(slots_in_use, SLOTS), a write request (command 0) fills or clears
// one slot below n in the accepting cycle (writes to others are dropped);
// it gives no result, and busy does not rise, so writes can follow back to
// back. A select request (command 1) raises busy while the slots below n are
// read in turn through the single memory read port and the one shared
// comparator; StLast compares the last read and StFin presents the result.
// With n equal to 0 there is no scan, and busy stays high for the single
// result cycle only. That result is on the chosen_* ports in the cycle in
// which result_strobe_o is high; the receiver cannot stall it, so capture it
// then. The winner has the lowest source, then sequence, then slot index,
// and its slot is emptied. With nothing occupied, found_o is 0 and every
// other field is 0. Write slots_in_use only while busy is low.
module priority_request_buffer_select #(
  parameter int unsigned SLOTS      = prbs_pkg::SlotsDefault,
  parameter int unsigned MAX_SOURCE = prbs_pkg::MaxSourceDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prbs_pkg::SiuW-1:0]      cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command_i,
  input  logic [prbs_pkg::SlotW-1:0]     slot_i,
  input  logic [prbs_pkg::SourceW-1:0]   source_i,
  input  logic [prbs_pkg::SequenceW-1:0] sequence_req_i,
  input  logic [prbs_pkg::StampW-1:0]    stamp_i,
  output logic                           result_strobe_o,
  output logic                           found_o,
  output logic [prbs_pkg::SourceW-1:0]   chosen_source_o,
  output logic [prbs_pkg::SequenceW-1:0] chosen_sequence_o,
  output logic [prbs_pkg::StampW-1:0]    chosen_stamp_o,
  output logic [prbs_pkg::SlotW-1:0]     chosen_slot_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CntW > prbs_pkg::SiuW) ? CntW : prbs_pkg::SiuW;

  localparam logic [CmpW-1:0]              SlotsCnt  = CmpW'(SLOTS);
  localparam logic [7:0]                   MaxSrc8   = 8'(MAX_SOURCE);
  localparam logic [prbs_pkg::SourceW-1:0] MaxSrcLim = prbs_pkg::SourceW'(MAX_SOURCE);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StLast = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [prbs_pkg::SiuW-1:0] siu_q;
  logic [CmpW-1:0]           n_lim;
  logic [IW-1:0]             rd_idx_q, rd_idx_d;
  logic                      cand_v_q;

  logic                  accept;
  logic                  wr_en;
  logic                  sel_go;
  prbs_pkg::slot_entry_t wr_entry;
  logic [prbs_pkg::SourceW-1:0] src_sat;

  prbs_pkg::slot_entry_t rd_entry;
  logic                  rd_occ;
  logic [IW-1:0]         rd_idx;

  logic                  have;
  prbs_pkg::slot_entry_t best_entry;
  logic [IW-1:0]         best_idx;

  // Effective slot count: the register, capped at the slot count.
  assign n_lim = (CmpW'(siu_q) > SlotsCnt) ? SlotsCnt : CmpW'(siu_q);

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign sel_go = accept && (prbs_pkg::cmd_e'(command_i) == prbs_pkg::CmdSelect);

  // Saturate the written source, and drop writes outside the active range.
  assign src_sat = (8'(source_i) > MaxSrc8) ? MaxSrcLim : source_i;
  assign wr_en   = accept && (prbs_pkg::cmd_e'(command_i) == prbs_pkg::CmdWrite) &&
                   (CmpW'(slot_i) < n_lim);

  always_comb begin
    wr_entry              = '0;
    wr_entry.source       = src_sat;
    wr_entry.sequence_num = sequence_req_i;
    wr_entry.stamp        = stamp_i;
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      siu_q <= prbs_pkg::SiuReset;
    end else if (cfg_we_i) begin
      siu_q <= cfg_wdata_i;
    end
  end

  // Sequencer: issue one slot read per cycle and compare each read in the next cycle.
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    case (state_q)
      StIdle: begin
        if (sel_go) begin
          rd_idx_d = '0;
          state_d  = (n_lim == '0) ? StFin : StScan;
        end
      end
      StScan: begin
        if (CmpW'(rd_idx_q) == (n_lim - CmpW'(1))) begin
          state_d = StLast;
        end else begin
          rd_idx_d = rd_idx_q + IW'(1);
        end
      end
      StLast: begin
        state_d = StFin;
      end
      StFin: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_idx_q <= '0;
      cand_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      cand_v_q <= (state_q == StScan);
    end
  end

  prbs_slot_store #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (IW'(slot_i)),
    .wr_entry_i (wr_entry),
    .clr_en_i   ((state_q == StFin) && have),
    .clr_idx_i  (best_idx),
    .rd_en_i    (state_q == StScan),
    .rd_idx_i   (rd_idx_q),
    .rd_entry_o (rd_entry),
    .rd_occ_o   (rd_occ),
    .rd_idx_o   (rd_idx)
  );

  prbs_scan_unit #(
    .IW (IW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_i       (sel_go),
    .cand_valid_i (cand_v_q),
    .cand_occ_i   (rd_occ),
    .cand_entry_i (rd_entry),
    .cand_idx_i   (rd_idx),
    .have_o       (have),
    .best_entry_o (best_entry),
    .best_idx_o   (best_idx)
  );

  // Strobe the result in the single finishing cycle. The best registers
  // were cleared at the start of the select, so an empty scan reads as zero.
  assign result_strobe_o   = (state_q == StFin);
  assign found_o           = have;
  assign chosen_source_o   = best_entry.source;
  assign chosen_sequence_o = best_entry.sequence_num;
  assign chosen_stamp_o    = best_entry.stamp;
  assign chosen_slot_o     = prbs_pkg::SlotW'(best_idx);

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for priority_request_buffer_select: directed and random requests.
// Depends on prbs_pkg and the block's RTL; a scoreboard class mirrors the slot buffer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SourceW      = prbs_pkg::SourceW;
  localparam int unsigned SequenceW    = prbs_pkg::SequenceW;
  localparam int unsigned StampW       = prbs_pkg::StampW;
  localparam int unsigned SlotW        = prbs_pkg::SlotW;
  localparam int unsigned SiuW         = prbs_pkg::SiuW;

  localparam int unsigned Slots        = prbs_pkg::SlotsDefault;
  localparam int unsigned MaxSource    = prbs_pkg::MaxSourceDefault;
  // A write lands in its accepting cycle; a select must scan its slots first. Leave margin.
  localparam int unsigned SettleCycles = prbs_pkg::SlotsDefault + 4;
  localparam int unsigned MaxReports   = 10;
  // Sender schedule: one drain in the middle, one stretch with no idling.
  localparam int unsigned PauseAt      = 120;
  localparam int unsigned QuietFrom    = 180;
  localparam int unsigned QuietTo      = 300;
  localparam int unsigned TimeoutNs    = 2_000_000;

  // One expected pick, as the result ports present it.
  typedef struct packed {
    logic                 found;
    logic [SourceW-1:0]   source;
    logic [SequenceW-1:0] seq_num;
    logic [StampW-1:0]    stamp;
    logic [SlotW-1:0]     slot;
  } pick_t;

  // Mirror of the slot buffer plus the queue of picks still owed by the block.
  class pick_tracker;
    logic [SiuW-1:0]      slot_count;
    logic [SourceW-1:0]   held_source [Slots];
    logic [SequenceW-1:0] held_seq    [Slots];
    logic [StampW-1:0]    held_stamp  [Slots];
    pick_t                owed_picks  [$];
    int unsigned          errors;

    function new();
      slot_count = prbs_pkg::SiuReset;
      errors     = 0;
      for (int i = 0; i < Slots; i++) begin
        held_source[i] = '0;
        held_seq[i]    = '0;
        held_stamp[i]  = '0;
      end
    endfunction

    function void set_slot_count(logic [SiuW-1:0] value);
      slot_count = value;
    endfunction

    // Register values above the slot count saturate.
    function int unsigned live_slots();
      return (slot_count > Slots) ? Slots : int'(slot_count);
    endfunction

    function int unsigned pending();
      return owed_picks.size();
    endfunction

    // Apply one accepted request; a select queues the pick it must produce.
    function void note_request(prbs_pkg::cmd_e cmd, logic [SlotW-1:0] slot,
                               logic [SourceW-1:0] src, logic [SequenceW-1:0] seq_num,
                               logic [StampW-1:0] stamp);
      int unsigned n;
      int unsigned best;
      bit          have;
      pick_t       pick;
      n    = live_slots();
      best = 0;
      have = 1'b0;
      pick = '0;
      if (cmd == prbs_pkg::CmdWrite) begin
        if (src > MaxSource) src = SourceW'(MaxSource);
        // Drop writes beyond the live range; those slots keep their contents.
        if (slot < n) begin
          held_source[slot] = src;
          held_seq[slot]    = seq_num;
          held_stamp[slot]  = stamp;
        end
        return;
      end
      // Lowest source wins, then lowest sequence, then lowest slot index.
      for (int unsigned i = 0; i < n; i++) begin
        if (held_source[i] != '0) begin
          if (!have || held_source[i] < held_source[best] ||
              (held_source[i] == held_source[best] && held_seq[i] < held_seq[best])) begin
            best = i;
            have = 1'b1;
          end
        end
      end
      if (have) begin
        pick.found   = 1'b1;
        pick.source  = held_source[best];
        pick.seq_num = held_seq[best];
        pick.stamp   = held_stamp[best];
        pick.slot    = best[SlotW-1:0];
        held_source[best] = '0;
      end
      owed_picks.push_back(pick);
    endfunction

    function void check_pick(logic found, logic [SourceW-1:0] src,
                             logic [SequenceW-1:0] seq_num, logic [StampW-1:0] stamp,
                             logic [SlotW-1:0] slot);
      pick_t want;
      if (owed_picks.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result found=%0b src=%0d seq=%h stamp=%h slot=%0d",
                   $realtime, found, src, seq_num, stamp, slot);
        return;
      end
      want = owed_picks.pop_front();
      if (found !== want.found || src !== want.source || seq_num !== want.seq_num ||
          stamp !== want.stamp || slot !== want.slot) begin
        errors++;
        if (errors <= MaxReports)
          $display({"%0t: mismatch exp found=%0b src=%0d seq=%h stamp=%h slot=%0d",
                    " / got found=%0b src=%0d seq=%h stamp=%h slot=%0d"},
                   $realtime, want.found, want.source, want.seq_num, want.stamp, want.slot,
                   found, src, seq_num, stamp, slot);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [SiuW-1:0]      cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic                 command_i;
  logic [SlotW-1:0]     slot_i;
  logic [SourceW-1:0]   source_i;
  logic [SequenceW-1:0] sequence_req_i;
  logic [StampW-1:0]    stamp_i;
  logic                 result_strobe_o;
  logic                 found_o;
  logic [SourceW-1:0]   chosen_source_o;
  logic [SequenceW-1:0] chosen_sequence_o;
  logic [StampW-1:0]    chosen_stamp_o;
  logic [SlotW-1:0]     chosen_slot_o;

  pick_tracker picks = new();
  int unsigned item_count;

  priority_request_buffer_select u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .slot_i            (slot_i),
    .source_i          (source_i),
    .sequence_req_i    (sequence_req_i),
    .stamp_i           (stamp_i),
    .result_strobe_o   (result_strobe_o),
    .found_o           (found_o),
    .chosen_source_o   (chosen_source_o),
    .chosen_sequence_o (chosen_sequence_o),
    .chosen_stamp_o    (chosen_stamp_o),
    .chosen_slot_o     (chosen_slot_o)
  );

  always #6 clk_i = ~clk_i;

  // Capture each result in its strobe cycle; outputs are read before this edge updates them.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_strobe_o === 1'b1)
      picks.check_pick(found_o, chosen_source_o, chosen_sequence_o, chosen_stamp_o,
                       chosen_slot_o);
  end

  // Present a request and hold it until an edge sees busy low. Called at a rising edge;
  // start stays high on return so a following request goes out back to back.
  task automatic send_request(prbs_pkg::cmd_e cmd, logic [SlotW-1:0] slot,
                              logic [SourceW-1:0] src, logic [SequenceW-1:0] seq_num,
                              logic [StampW-1:0] stamp);
    start          <= 1'b1;
    command_i      <= cmd;
    slot_i         <= slot;
    source_i       <= src;
    sequence_req_i <= seq_num;
    stamp_i        <= stamp;
    do @(posedge clk_i); while (busy !== 1'b0);
    picks.note_request(cmd, slot, src, seq_num, stamp);
  endtask

  task automatic idle_cycles(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every owed pick has come back, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (picks.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_slot_count(logic [SiuW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    picks.set_slot_count(value);
    cfg_we_i    <= 1'b0;
  endtask

  // Random requests until `target` of them did something (select, or write in range).
  task automatic run_phase(int unsigned target);
    int unsigned          done;
    int unsigned          n;
    bit                   noisy;
    prbs_pkg::cmd_e       cmd;
    logic [SlotW-1:0]     slot;
    logic [SourceW-1:0]   src;
    logic [SequenceW-1:0] seq_num;
    logic [StampW-1:0]    stamp;
    done = 0;
    while (done < target) begin
      n     = picks.live_slots();
      noisy = ($urandom_range(0, 99) < 15);
      cmd   = ($urandom_range(0, 99) < 35) ? prbs_pkg::CmdSelect : prbs_pkg::CmdWrite;
      if (!noisy && n != 0) slot = SlotW'($urandom_range(0, n - 1));
      else slot = SlotW'($urandom_range(0, Slots - 1));
      // Favor few sources and small sequences so ties are common.
      case ($urandom_range(0, 9))
        0:          src = '0;
        1, 2, 3, 4: src = SourceW'($urandom_range(1, 3));
        default:    src = SourceW'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 1) == 1) seq_num = SequenceW'($urandom_range(0, 3));
      else seq_num = SequenceW'($urandom_range(0, 65535));
      stamp = $urandom();
      send_request(cmd, slot, src, seq_num, stamp);
      if (cmd == prbs_pkg::CmdSelect || slot < n) done++;
      item_count++;
      if (item_count == PauseAt)
        drain();
      else if ((item_count < QuietFrom || item_count > QuietTo) && $urandom_range(0, 99) < 14)
        idle_cycles($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    start          = 1'b0;
    command_i      = prbs_pkg::CmdWrite;
    slot_i         = '0;
    source_i       = '0;
    sequence_req_i = '0;
    stamp_i        = '0;
    item_count     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty buffer right after reset.
    send_request(prbs_pkg::CmdSelect, 3'd0, 4'd0, 16'h0000, 32'h0000_0000);
    // Extremes, a source tie broken by slot index, a sequence tie-break, a clearing write.
    send_request(prbs_pkg::CmdWrite, 3'd0, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(prbs_pkg::CmdWrite, 3'd7, 4'd1, 16'h0000, 32'h0000_0000);
    send_request(prbs_pkg::CmdWrite, 3'd3, 4'd1, 16'h0000, 32'h1234_5678);
    send_request(prbs_pkg::CmdWrite, 3'd5, 4'd1, 16'h0009, 32'hA5A5_A5A5);
    send_request(prbs_pkg::CmdWrite, 3'd5, 4'd0, 16'h0000, 32'h0000_0000);
    send_request(prbs_pkg::CmdWrite, 3'd2, 4'd1, 16'hFFFF, 32'h5A5A_5A5A);
    repeat (5) send_request(prbs_pkg::CmdSelect, 3'd0, 4'd0, 16'h0000, 32'h0000_0000);

    // Narrow range: writes past it are dropped.
    write_slot_count(4'd3);
    send_request(prbs_pkg::CmdWrite, 3'd6, 4'd2, 16'h0001, 32'hDEAD_BEEF);
    send_request(prbs_pkg::CmdWrite, 3'd2, 4'd9, 16'h0007, 32'h0BAD_F00D);
    repeat (2) send_request(prbs_pkg::CmdSelect, 3'd0, 4'd0, 16'h0000, 32'h0000_0000);

    // Shrink over live slots, then zero, then above the slot count.
    write_slot_count(4'd8);
    send_request(prbs_pkg::CmdWrite, 3'd4, 4'd4, 16'h0044, 32'h4444_4444);
    send_request(prbs_pkg::CmdWrite, 3'd6, 4'd6, 16'h0066, 32'h6666_6666);
    write_slot_count(4'd2);
    send_request(prbs_pkg::CmdSelect, 3'd0, 4'd0, 16'h0000, 32'h0000_0000);
    write_slot_count(4'd0);
    send_request(prbs_pkg::CmdWrite, 3'd0, 4'd3, 16'h0003, 32'h3333_3333);
    send_request(prbs_pkg::CmdSelect, 3'd0, 4'd0, 16'h0000, 32'h0000_0000);
    write_slot_count(4'd15);
    repeat (3) send_request(prbs_pkg::CmdSelect, 3'd0, 4'd0, 16'h0000, 32'h0000_0000);

    // Random phases across several range settings; slots outside a range carry over.
    write_slot_count(4'd8);
    run_phase(90);
    write_slot_count(4'd1);
    run_phase(60);
    write_slot_count(4'd15);
    run_phase(90);
    write_slot_count(4'd5);
    run_phase(80);
    write_slot_count(4'd0);
    run_phase(20);
    write_slot_count(SiuW'($urandom_range(2, 7)));
    run_phase(80);
    write_slot_count(4'd8);
    run_phase(80);

    drain();
    if (picks.errors == 0 && picks.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Bound the run far beyond the slowest correct schedule.
  initial begin
    #(TimeoutNs);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
hdl/prbs_pkg.sv
hdl/prbs_slot_store.sv
hdl/prbs_scan_unit.sv
hdl/priority_request_buffer_select.sv
tb/sv/tb.sv
